FILE: hdl/bfw_pkg.sv
// ----------------------------------------------------------------------------
// bfw_pkg
// Shared types and constants of the bit field writer: command codes, the
// field entry that travels from the front end to the packer, and sizes.
// ----------------------------------------------------------------------------
package bfw_pkg;

  // Command codes on the cmd port
  localparam logic [1:0] CMD_PLAIN  = 2'd0;
  localparam logic [1:0] CMD_VARINT = 2'd1;
  localparam logic [1:0] CMD_PAD    = 2'd2;

  // Octal digits of a 32-bit number, and the widest field they make
  localparam int NumDigits = 11;
  localparam int FieldBits = 4 * NumDigits;
  // Packing window: one partial byte plus room for the widest field
  localparam int WinBits   = 56;
  // Entries in the queue between front end and packer
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  // One classified command, field bits left-justified
  typedef struct packed {
    logic                 pad;
    logic [5:0]           nbits;
    logic [FieldBits-1:0] data;
  } bfw_entry_t;

  // Packer status seen by the top level checks
  typedef struct packed {
    logic       load;
    logic [5:0] cnt;
  } bfw_back_status_t;

endpackage

FILE: hdl/bfw_front.sv
// ----------------------------------------------------------------------------
// bfw_front
// Classifies one command into a left-justified bit field and a bit count.
// Plain fields keep their low bits, variable-length integers become a run of
// marked octal digits, pads are passed on for the packer to size.
// ----------------------------------------------------------------------------
module bfw_front import bfw_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        take,
  input  logic [1:0]  cmd,
  input  logic [31:0] value,
  input  logic [5:0]  width,
  output logic        wr,
  output bfw_entry_t  entry
);

  localparam int PlainCap = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam logic [31:0] ValueMask =
    (VALUE_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << VALUE_BITS) - 64'd1);

  logic [3*NumDigits-1:0] mv;
  logic [FieldBits-1:0]   digits;
  logic [FieldBits-1:0]   raw;
  logic [3:0]             top;
  logic [3:0]             ndig;
  logic [5:0]             wcap;
  logic [5:0]             nbits;

  // Mask the value to the number width
  assign mv = {1'b0, value & ValueMask};

  // Build every digit nibble; the lowest carries the end mark
  always_comb begin
    for (int k = 0; k < NumDigits; k++) begin
      digits[4*k +: 4] = {(k == 0), mv[3*k +: 3]};
    end
  end

  // Find the leading nonzero digit
  always_comb begin
    top = 4'd0;
    for (int k = 1; k < NumDigits; k++) begin
      if (mv[3*k +: 3] != 3'd0) begin
        top = 4'(k);
      end
    end
  end

  assign ndig = top + 4'd1;
  assign wcap = (width > 6'(PlainCap)) ? 6'(PlainCap) : width;

  // Select field bits and length per command
  always_comb begin
    raw   = '0;
    nbits = '0;
    wr    = 1'b0;
    unique case (cmd)
      CMD_PLAIN: begin
        raw   = {{(FieldBits-32){1'b0}}, value};
        nbits = wcap;
        wr    = take;
      end
      CMD_VARINT: begin
        raw   = digits;
        nbits = {ndig, 2'b00};
        wr    = take;
      end
      CMD_PAD: begin
        wr    = take;
      end
      default: begin
        wr    = 1'b0;
      end
    endcase
  end

  // Left-justify; bits above the field length fall off the top
  assign entry.pad   = (cmd == CMD_PAD);
  assign entry.nbits = nbits;
  assign entry.data  = raw << (6'(FieldBits) - nbits);

endmodule

FILE: hdl/bfw_queue.sv
// ----------------------------------------------------------------------------
// bfw_queue
// Short first-in first-out queue of classified commands between the front
// end and the packer. The head entry is shown while not empty.
// ----------------------------------------------------------------------------
module bfw_queue import bfw_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr,
  input  bfw_entry_t wdata,
  output logic       full,
  input  logic       rd,
  output logic       valid,
  output bfw_entry_t rdata
);

  bfw_entry_t           slots [QueueDepth];
  logic [QueueAw-1:0]   wp;
  logic [QueueAw-1:0]   rp;
  logic [QueueAw:0]     count;

  assign full  = (count == (QueueAw+1)'(QueueDepth));
  assign valid = (count != '0);
  assign rdata = slots[rp];

  // Store incoming entries
  always_ff @(posedge clk) begin
    if (wr && !full) begin
      slots[wp] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wp <= wp + 1'b1;
      end
      if (rd && valid) begin
        rp <= rp + 1'b1;
      end
      case ({wr && !full, rd && valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: hdl/bfw_back.sv
// ----------------------------------------------------------------------------
// bfw_back
// Packer: merges queued fields into a bit window behind the partial byte and
// emits one completed byte per cycle into the output register while free.
// ----------------------------------------------------------------------------
module bfw_back import bfw_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  bfw_entry_t       q_data,
  output logic             q_rd,
  output logic [7:0]       out_byte,
  output logic             last,
  output logic             empty,
  input  logic             pop,
  output bfw_back_status_t status
);

  logic [WinBits-1:0] win;
  logic [WinBits-1:0] win_next;
  logic [5:0]         cnt;
  logic [5:0]         cnt_next;
  logic               ovalid;
  logic               emit;
  logic [WinBits-1:0] base_win;
  logic [5:0]         base_cnt;
  logic [5:0]         add_bits;
  logic [FieldBits-1:0] add_data;

  // Emit a byte when one is complete and the output slot frees up
  assign emit     = (cnt >= 6'd8) && (!ovalid || pop);
  assign base_win = emit ? (win << 8) : win;
  assign base_cnt = emit ? (cnt - 6'd8) : cnt;
  assign q_rd     = q_valid && (base_cnt < 6'd8);

  // Pads fill up to the next byte boundary
  always_comb begin
    if (q_data.pad) begin
      add_bits = {3'b000, 3'd0 - base_cnt[2:0]};
      add_data = '0;
    end else begin
      add_bits = q_data.nbits;
      add_data = q_data.data;
    end
  end

  // Merge the next field behind the pending bits
  always_comb begin
    win_next = base_win;
    cnt_next = base_cnt;
    if (q_rd) begin
      win_next = base_win | ({add_data, {(WinBits-FieldBits){1'b0}}} >> base_cnt[2:0]);
      cnt_next = base_cnt + add_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
      cnt <= '0;
    end else begin
      win <= win_next;
      cnt <= cnt_next;
    end
  end

  // Hold the result until popped
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (emit) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= win[WinBits-1 -: 8];
      last     <= (cnt < 6'd16);
    end
  end

  assign empty       = !ovalid;
  assign status.load = q_rd;
  assign status.cnt  = cnt;

endmodule

FILE: hdl/bitstream_field_writer.sv
// ----------------------------------------------------------------------------
// bitstream_field_writer
// Packs bit fields MSB first into a byte stream.
//
// Input queue: a command (cmd, value, width) is taken at a clock edge with
// push high and full low. Plain fields write the low width bits of value,
// variable-length integers write marked octal digits, pads align to a byte.
// Result queue: while empty is low, out_byte and last show the oldest byte;
// pop takes it. last flags the final byte a command completed.
// The first byte of a command passes through the queue, the packer's bit
// window and its single output register, which takes one byte per cycle
// while the receiver keeps popping.
// A four-entry queue sits between the classifier and the packer.
// Reset empties both queues and clears the partial byte and its bit offset.
// When the receiver stalls, the packer holds its bytes, the queue fills and
// full rises; no byte is lost or repeated.
// ----------------------------------------------------------------------------
module bitstream_field_writer import bfw_pkg::*; #(
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  cmd,
  input  logic [31:0] value,
  input  logic [5:0]  width,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last
);

  logic             fe_wr;
  bfw_entry_t       fe_entry;
  logic             q_valid;
  logic             q_rd;
  bfw_entry_t       q_data;
  bfw_back_status_t bk_status;

  // Classify incoming transactions
  bfw_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .take  (push && !full),
    .cmd   (cmd),
    .value (value),
    .width (width),
    .wr    (fe_wr),
    .entry (fe_entry)
  );

  // Decouple front end and packer
  bfw_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (fe_wr),
    .wdata (fe_entry),
    .full  (full),
    .rd    (q_rd),
    .valid (q_valid),
    .rdata (q_data)
  );

  // Pack and emit bytes
  bfw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_rd     (q_rd),
    .out_byte (out_byte),
    .last     (last),
    .empty    (empty),
    .pop      (pop),
    .status   (bk_status)
  );

  // Pending bits never exceed one partial byte plus the widest field
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    bk_status.cnt <= 6'(FieldBits + 7))
    else $error("packer bit count out of range");

  // The packer only leaves a queued field waiting while it holds a full byte
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    (q_valid && !bk_status.load) |-> (bk_status.cnt >= 6'd8))
    else $error("packer stalled with no byte to emit");

  // Reset leaves no result waiting
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("result present right after reset");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench of the bit field writer. A driver pushes commands (plain
// fields, variable-length integers, pads and unused codes) from a queue that
// the stimulus block fills. A predictor packs the same bits MSB first and
// queues the bytes each command completes. A monitor pops the result queue
// and compares every byte and its last flag with the oldest prediction.
// Flow control runs in three phases of random idling on either side, and
// includes one long receiver hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb;
  import bfw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnused  = 2'd3;
  localparam int         PlainCap   = 32;
  localparam int         TopShift   = ((32 - 1) / 3) * 3;
  localparam int         RandomCmds = 180;
  localparam int         HoldAt     = 175;
  localparam int         HoldCycles = 150;
  localparam int         DrainWait  = 16;
  localparam int         CycleLimit = 200000;
  localparam int         MaxPrinted = 20;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] value;
    logic [5:0]  width;
  } field_cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [1:0]  cmd = CMD_PLAIN;
  logic [31:0] value = '0;
  logic [5:0]  width = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  out_byte;
  logic        last;

  field_cmd_t   pending_cmds[$];
  stream_byte_t expected_bytes[$];
  logic [7:0]   fresh_bytes[$];

  // Packing state of the predictor
  logic [7:0]   stream_acc = '0;
  int unsigned  stream_fill = 0;

  logic         hold_rx = 1'b0;
  int unsigned  accepted_cnt = 0;
  int unsigned  plain_cnt = 0;
  int unsigned  varint_cnt = 0;
  int unsigned  pad_cnt = 0;
  int unsigned  unused_cnt = 0;
  int unsigned  bytes_seen = 0;
  int unsigned  full_cycles = 0;
  int unsigned  mismatch_cnt = 0;
  int unsigned  cycle_cnt = 0;

  field_cmd_t   next_cmd;
  stream_byte_t want;

  bitstream_field_writer u_top (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .value    (value),
    .width    (width),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last)
  );

  always #2 clk = ~clk;

  // Append bits MSB first, collecting each completed byte
  task automatic append_bits(input logic [63:0] bits, input int n);
    for (int i = n; i > 0; i--) begin
      stream_acc[7 - stream_fill] = bits[i - 1];
      stream_fill++;
      if (stream_fill == 8) begin
        fresh_bytes.push_back(stream_acc);
        stream_acc  = '0;
        stream_fill = 0;
      end
    end
  endtask

  // Work out the bytes one command completes and queue them
  task automatic predict_command(input field_cmd_t c);
    int          w;
    bit          seen;
    logic [31:0] shifted;
    logic [63:0] mask;
    fresh_bytes.delete();
    case (c.cmd)
      CMD_PLAIN: begin
        w = (c.width > PlainCap) ? PlainCap : int'(c.width);
        if (w > 0) begin
          mask = (64'd1 << w) - 64'd1;
          append_bits(64'(c.value) & mask, w);
        end
      end
      CMD_VARINT: begin
        seen = 1'b0;
        for (int sh = TopShift; sh > 0; sh -= 3) begin
          shifted = c.value >> sh;
          if (seen || shifted[2:0] != 3'd0) begin
            append_bits(64'(shifted[2:0]), 4);
            seen = 1'b1;
          end
        end
        append_bits(64'(c.value[2:0]) + 64'd8, 4);
      end
      CMD_PAD: begin
        if (stream_fill != 0) append_bits(64'd0, 8 - stream_fill);
      end
      default: ;
    endcase
    foreach (fresh_bytes[i])
      expected_bytes.push_back('{data: fresh_bytes[i], last: (i == fresh_bytes.size() - 1)});
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp_val);
    if (mismatch_cnt < MaxPrinted)
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_cnt, what, got,
               exp_val);
    mismatch_cnt++;
  endtask

  // Idle percentages by phase: sender-heavy, receiver-heavy, then none
  function automatic int send_idle_pct();
    if (accepted_cnt < 80) return 33;
    if (accepted_cnt < 160) return 72;
    return 0;
  endfunction

  function automatic int recv_idle_pct();
    if (accepted_cnt < 80) return 72;
    if (accepted_cnt < 160) return 33;
    return 0;
  endfunction

  function automatic field_cmd_t random_cmd();
    field_cmd_t c;
    int         r;
    r = $urandom_range(99);
    if (r < 45) c.cmd = CMD_PLAIN;
    else if (r < 80) c.cmd = CMD_VARINT;
    else if (r < 95) c.cmd = CMD_PAD;
    else c.cmd = CmdUnused;
    case ($urandom_range(3))
      0: c.value = $urandom;
      1: c.value = $urandom >> $urandom_range(31);
      2: c.value = $urandom_range(15);
      default: c.value = $urandom_range(1) ? 32'hffff_ffff : 32'h0;
    endcase
    if ($urandom_range(9) == 0) c.width = 6'($urandom_range(63, 33));
    else c.width = 6'($urandom_range(32));
    return c;
  endfunction

  // Driver: predict accepted transactions, offer the next command
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_command('{cmd: cmd, value: value, width: width});
        accepted_cnt++;
        case (cmd)
          CMD_PLAIN:  plain_cnt++;
          CMD_VARINT: varint_cnt++;
          CMD_PAD:    pad_cnt++;
          default:    unused_cnt++;
        endcase
      end
      if (push && full) full_cycles++;
      if (!push || !full) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
          next_cmd = pending_cmds.pop_front();
          push  <= 1'b1;
          cmd   <= next_cmd.cmd;
          value <= next_cmd.value;
          width <= next_cmd.width;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each popped byte against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        bytes_seen++;
        if (expected_bytes.size() == 0) begin
          report_mismatch("unexpected byte", out_byte, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) report_mismatch("out_byte", out_byte, want.data);
          if (last !== want.last) report_mismatch("last", 8'(last), 8'(want.last));
        end
      end
      pop <= !hold_rx && ($urandom_range(99) >= recv_idle_pct());
    end
  end

  // Hold off the receiver for a long stretch so the block backs up
  initial begin
    do @(posedge clk); while (accepted_cnt < HoldAt);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
               expected_bytes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int real_cnt;
    field_cmd_t c;

    // Directed: extremes, saturation, masking, pads, varint lengths
    pending_cmds.push_back('{CMD_PLAIN,  32'hffff_ffff, 6'd0});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0000_0001, 6'd1});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0000_007f, 6'd7});
    pending_cmds.push_back('{CMD_PAD,    32'hffff_ffff, 6'd63});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0000_0005, 6'd3});
    pending_cmds.push_back('{CMD_PAD,    32'h0,         6'd0});
    pending_cmds.push_back('{CMD_PLAIN,  32'hffff_ffff, 6'd32});
    pending_cmds.push_back('{CMD_PLAIN,  32'ha5a5_a5a5, 6'd33});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0,         6'd63});
    pending_cmds.push_back('{CMD_PLAIN,  32'hffff_ffe0, 6'd5});
    pending_cmds.push_back('{CMD_VARINT, 32'h0,         6'd0});
    pending_cmds.push_back('{CMD_VARINT, 32'h0000_0007, 6'd0});
    pending_cmds.push_back('{CMD_VARINT, 32'h0000_0008, 6'd0});
    pending_cmds.push_back('{CMD_VARINT, 32'h4000_0000, 6'd0});
    pending_cmds.push_back('{CMD_PAD,    32'h0,         6'd0});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0000_0001, 6'd7});
    pending_cmds.push_back('{CMD_VARINT, 32'hffff_ffff, 6'd63});
    pending_cmds.push_back('{CmdUnused,  32'hffff_ffff, 6'd63});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0000_0009, 6'd4});
    pending_cmds.push_back('{CMD_PAD,    32'h0,         6'd0});
    pending_cmds.push_back('{CMD_PLAIN,  32'h0000_00a5, 6'd8});
    pending_cmds.push_back('{CMD_VARINT, 32'hffff_ffff, 6'd0});

    // Random: unused codes do not count toward the total
    real_cnt = 0;
    while (real_cnt < RandomCmds) begin
      c = random_cmd();
      pending_cmds.push_back(c);
      if (c.cmd != CmdUnused) real_cnt++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: all commands taken and every predicted byte seen
    while (pending_cmds.size() != 0 || push || expected_bytes.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    $display("Ran %0d commands: %0d plain, %0d varint, %0d pad, %0d unused", accepted_cnt,
             plain_cnt, varint_cnt, pad_cnt, unused_cnt);
    $display("Checked %0d stream bytes; input stalled on full for %0d cycles", bytes_seen,
             full_cycles);
    if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/bfw_pkg.sv
hdl/bfw_front.sv
hdl/bfw_queue.sv
hdl/bfw_back.sv
hdl/bitstream_field_writer.sv
bench/tb.sv
